[hw/rtl/tcgr_pkg.sv]
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   localparam int GLYPH_COUNT = 256;
   localparam int GLYPH_ROWS  = 16;
   localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
   localparam int FONT_AW     = $clog2(FONT_DEPTH);
   localparam int FONT_IW     = ((FONT_AW > 12) ? FONT_AW : 12) + 1;

   localparam logic [7:0]  NEWLINE_CODE = 8'd10;
   localparam logic [11:0] CURSOR_MAX   = 12'hFFF;

   typedef enum logic [1:0] {
      CSR_FRAME_BASE    = 2'd0,
      CSR_LINE_PITCH    = 2'd1,
      CSR_SCREEN_WIDTH  = 2'd2,
      CSR_SCREEN_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_DRAW = 1'b0,
      CMD_LOAD = 1'b1
   } command_type;

   typedef struct packed {
      logic        command;
      logic [7:0]  char_code;
      logic [31:0] color;
      logic [11:0] font_index;
      logic [7:0]  font_bits;
   } req_word_type;

   typedef struct packed {
      logic [29:0] pixel_address;
      logic [7:0]  pixel_mask;
      logic [31:0] pixel_color;
      logic        last_row;
   } rsp_word_type;

   typedef struct packed {
      logic               en;
      logic [FONT_AW-1:0] addr;
      logic [7:0]         data;
   } font_wr_type;

   function automatic logic [7:0] reverse8(input logic [7:0] b);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[7-k] = b[k];
      end
      return r;
   endfunction

   function automatic logic [11:0] sat_inc(input logic [11:0] v);
      return (v == CURSOR_MAX) ? v : v + 12'd1;
   endfunction

endpackage

[hw/rtl/tcgr_font_store.sv]
// ----------------------------------------------------------------------------
// tcgr_font_store
// Glyph row memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcgr_font_store (
   input  logic                         clock,
   input  tcgr_pkg::font_wr_type        wr,
   input  logic [tcgr_pkg::FONT_AW-1:0] rd_addr,
   output logic [7:0]                   rd_data
);
   import tcgr_pkg::*;

   logic [7:0] mem [FONT_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/text_console_glyph_renderer.sv]
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Text console: font row loads, cursor moves and 8x16 glyph row pixel writes.
//
//  channel | ports                          | direction | moves
//  req     | req_valid req_stall req_data   | in        | command word
//  rsp     | rsp_valid rsp_stall rsp_data   | out       | glyph row write word
//  csr     | csr_valid csr_ready csr_index  | in        | register write word
//          | csr_wdata                      |           |
//
// A load or a newline is handled in S_IDLE, which it does not leave.
// A drawn character takes 3 setup steps (wrap, multiply, base add) and then
// 16 glyph rows, one glyph row per cycle while rsp is not stalled, each adding
// the line pitch to the address and using the single font store read port.
// A stalled rsp holds the sequencer on its current row.
// Reset clears cursor and frame base and loads default pitch, width and height;
// the font store is not cleared.
module text_console_glyph_renderer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcgr_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcgr_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   import tcgr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRAP,
      S_MUL,
      S_BASE,
      S_EMIT
   } state_type;

   state_type    state_ff, state_in;
   logic [29:0]  frame_base_ff, frame_base_in;
   logic [12:0]  line_pitch_ff, line_pitch_in;
   logic [12:0]  screen_width_ff, screen_width_in;
   logic [12:0]  screen_height_ff, screen_height_in;
   logic [11:0]  col_ff, col_in;
   logic [11:0]  row_ff, row_in;
   logic [7:0]   ch_ff, ch_in;
   logic [31:0]  color_ff, color_in;
   logic [24:0]  prod_ff, prod_in;
   logic [29:0]  addr_ff, addr_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         rd_ok_ff, rd_ok_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;

   font_wr_type        font_wr;
   logic [FONT_IW-1:0] load_idx;
   logic [FONT_IW-1:0] read_idx;
   logic [7:0]         font_rd;
   logic               req_fire;
   logic               emit_fire;
   logic [11:0]        row_wrapped;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign emit_fire = (state_ff == S_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign load_idx = FONT_IW'(req_data.font_index);
   assign read_idx = FONT_IW'({ch_ff, cnt_in});

   always_comb begin
      font_wr.en   = req_fire && (req_data.command == CMD_LOAD)
                     && (load_idx < FONT_IW'(FONT_DEPTH));
      font_wr.addr = load_idx[FONT_AW-1:0];
      font_wr.data = req_data.font_bits;
   end

   tcgr_font_store u_font_store (
      .clock   (clock),
      .wr      (font_wr),
      .rd_addr (read_idx[FONT_AW-1:0]),
      .rd_data (font_rd)
   );

   always_comb begin
      state_in         = state_ff;
      frame_base_in    = frame_base_ff;
      line_pitch_in    = line_pitch_ff;
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      ch_in            = ch_ff;
      color_in         = color_ff;
      prod_in          = prod_ff;
      addr_in          = addr_ff;
      cnt_in           = cnt_ff;
      rd_ok_in         = (read_idx < FONT_IW'(FONT_DEPTH));
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_data_in      = rsp_data_ff;
      row_wrapped      = ({row_ff, 4'b0} >= 16'(screen_height_ff)) ? 12'd0 : row_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_BASE:    frame_base_in    = csr_wdata[29:0];
            CSR_LINE_PITCH:    line_pitch_in    = csr_wdata[12:0];
            CSR_SCREEN_WIDTH:  screen_width_in  = csr_wdata[12:0];
            CSR_SCREEN_HEIGHT: screen_height_in = csr_wdata[12:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_data.command == CMD_DRAW)) begin
               if (req_data.char_code == NEWLINE_CODE) begin
                  col_in = 12'd0;
                  row_in = sat_inc(row_ff);
               end else begin
                  ch_in    = req_data.char_code;
                  color_in = req_data.color;
                  state_in = S_WRAP;
               end
            end
         end
         S_WRAP: begin
            if (16'({col_ff, 3'b0}) >= 16'(screen_width_ff)) begin
               col_in = 12'd0;
               row_in = sat_inc(row_wrapped);
            end else begin
               row_in = row_wrapped;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = 25'(line_pitch_ff) * 25'(row_ff);
            state_in = S_BASE;
         end
         S_BASE: begin
            addr_in  = frame_base_ff + 30'({prod_ff, 4'b0}) + 30'({col_ff, 3'b0});
            cnt_in   = 4'd0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pixel_address = addr_ff;
               rsp_data_in.pixel_mask    = rd_ok_ff ? reverse8(font_rd) : 8'd0;
               rsp_data_in.pixel_color   = color_ff;
               rsp_data_in.last_row      = (cnt_ff == 4'(GLYPH_ROWS - 1));
               addr_in                   = addr_ff + 30'(line_pitch_ff);
               cnt_in                    = cnt_ff + 4'd1;
               if (cnt_ff == 4'(GLYPH_ROWS - 1)) begin
                  col_in   = sat_inc(col_ff);
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      rd_ok_in = (read_idx < FONT_IW'(FONT_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         frame_base_ff    <= 30'd0;
         line_pitch_ff    <= 13'd1024;
         screen_width_ff  <= 13'd1024;
         screen_height_ff <= 13'd768;
         col_ff           <= 12'd0;
         row_ff           <= 12'd0;
         cnt_ff           <= 4'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         frame_base_ff    <= frame_base_in;
         line_pitch_ff    <= line_pitch_in;
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         cnt_ff           <= cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      ch_ff       <= ch_in;
      color_ff    <= color_in;
      prod_ff     <= prod_in;
      addr_ff     <= addr_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> req_stall)
      else $error("request taken during glyph emit");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && (cnt_ff == 4'(GLYPH_ROWS - 1))) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return after last glyph row");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      emit_fire |=> (rsp_valid && (rsp_data.last_row == ($past(cnt_ff) == 4'hF))))
      else $error("last_row flag out of step with row counter");

   a_wrap_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRAP) |=> (state_ff == S_MUL))
      else $error("setup sequence broken");

endmodule
